@@ design/scan_disk_scheduler_macros.svh @@
// Assertion macros shared by the scan disk scheduler RTL.
`ifndef SCAN_DISK_SCHEDULER_MACROS_SVH
`define SCAN_DISK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define SDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scan_disk_scheduler: same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define SDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scan_disk_scheduler: next-cycle check failed");
`else
`define SDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/sds_pkg.sv @@
// Types and constants for the scan disk scheduler.
package sds_pkg;
	localparam int MAX_REQ_DEF = 32;
	localparam int TRACK_W     = 16;
	localparam int SEEK_W      = 17;
	localparam int TCOUNT_W    = 17;
	localparam int CFG_IDX_W   = 2;

	localparam logic [SEEK_W-1:0]    SEEK_MAX    = {SEEK_W{1'b1}};
	localparam logic [TCOUNT_W-1:0]  TCOUNT_RST  = 17'd200;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RIGHT = 2'd2;

	typedef struct packed {
		logic [TRACK_W-1:0] request_track;
		logic               last_request;
	} req_item_t;

	typedef struct packed {
		logic [TRACK_W-1:0] served_track;
		logic [SEEK_W-1:0]  seek_total;
		logic               last_visit;
	} res_item_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_VISIT,
		ST_FLUSH
	} sds_state_t;

	// Control from the sequencer to the candidate picker.
	typedef struct packed {
		logic clear;  // drop the current best, new search follows
		logic vld;    // read data of this cycle is a store entry
		logic below;  // search under the start head (else above)
		logic mark;   // entry already served
	} pick_ctl_t;
endpackage

@@ design/sds_mem.sv @@
// Request store: one write port, one read port, registered read data.
module sds_mem import sds_pkg::*; #(
	parameter int DEPTH = MAX_REQ_DEF,
	parameter int AW    = 5
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [TRACK_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [TRACK_W-1:0] rdata
);
	logic [TRACK_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ design/sds_pick.sv @@
// Candidate picker: keeps the nearest unserved request on one side of the start head.
module sds_pick import sds_pkg::*; #(
	parameter int AW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pick_ctl_t           ctl,
	input  logic [TRACK_W-1:0]  rdata,
	input  logic [AW-1:0]       idx,
	input  logic [TRACK_W-1:0]  start_head,
	input  logic [TCOUNT_W-1:0] track_count,
	output logic                found,
	output logic [TRACK_W-1:0]  best_track,
	output logic [AW-1:0]       best_idx
);
	logic                found_q;
	logic [TRACK_W-1:0]  best_q;
	logic [AW-1:0]       best_idx_q;
	logic                in_range;
	logic                take;

	// strict compares: first stored among equal tracks wins
	always_comb begin
		in_range = {1'b0, rdata} < track_count;
		take = 1'b0;
		if (ctl.vld && !ctl.mark && in_range) begin
			if (ctl.below) begin
				take = (rdata < start_head) && (!found_q || rdata > best_q);
			end else begin
				take = (rdata > start_head) && (!found_q || rdata < best_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= rdata;
			best_idx_q <= idx;
		end
	end

	assign found      = found_q;
	assign best_track = best_q;
	assign best_idx   = best_idx_q;
endmodule

@@ design/scan_disk_scheduler.sv @@
// Top level of the SCAN (elevator) disk scheduler.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   req     | in        | req_valid/req_stall  | request_track, last_request
//   res     | out       | res_valid/res_stall  | served_track, seek_total, last_visit
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Requests load at one item per cycle into the request store.
// The item with last_request set starts a schedule; req_stall stays high until
// the final visit has moved into the output register. Each visit costs one pass
// over the store through its single read port, followed by a commit in
// ST_VISIT that waits while the held-back visit cannot move out.
// arst_n resets control state and config registers and clears served marks; no
// clearing pass is needed. One visit is held back so that last_visit is known when
// the item goes out; res_stall only delays the next commit, nothing is dropped.
`include "scan_disk_scheduler_macros.svh"
module scan_disk_scheduler import sds_pkg::*; #(
	parameter int MAX_REQUESTS = MAX_REQ_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_item_t            req,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_item_t            res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TCOUNT_W-1:0]  cfg_data
);
	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

	// configuration
	logic [TCOUNT_W-1:0] track_count_q;
	logic [TRACK_W-1:0]  start_head_q;
	logic                sweep_right_q;

	// sequencer
	sds_state_t          state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_idx_q;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic                phase_q;  // 0: first sweep, 1: after reversal
	logic [MAX_REQUESTS-1:0] marks_q;

	// head and seek
	logic [TRACK_W-1:0]  head_q;
	logic [SEEK_W-1:0]   seek_q;

	// held-back visit and output register
	res_item_t           pend_q;
	logic                pend_valid_q;
	res_item_t           res_q;
	logic                res_valid_q;

	// control decode
	logic                req_acc, load_wr, sched_start;
	logic                issue, scan_done, sched_end, visit_ok, visit_go, flush_go;
	logic                res_free, below;

	// datapath
	logic [TRACK_W-1:0]  rdata;
	logic                found;
	logic [TRACK_W-1:0]  best_track;
	logic [AW-1:0]       best_idx;
	pick_ctl_t           pick_ctl;
	logic [TCOUNT_W-1:0] tc_m1;
	logic [TRACK_W-1:0]  end_track;
	logic [TRACK_W-1:0]  target;
	logic [TRACK_W-1:0]  seek_step;
	logic [SEEK_W:0]     seek_sum;
	logic [SEEK_W-1:0]   seek_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= TCOUNT_RST;
			start_head_q  <= '0;
			sweep_right_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRACK_COUNT: track_count_q <= cfg_data;
				CFG_START_HEAD:  start_head_q  <= cfg_data[TRACK_W-1:0];
				CFG_SWEEP_RIGHT: sweep_right_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---- condition decode ----
	assign res_free    = !res_valid_q || !res_stall;
	assign req_acc     = req_valid && !req_stall;
	assign load_wr     = req_acc && (count_q < MAX_CNT);
	assign sched_start = req_acc && req.last_request;
	// first sweep searches under the head when going left, second sweep the other way
	assign below       = ~(sweep_right_q ^ phase_q);
	assign visit_ok    = !pend_valid_q || res_free;

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (sched_start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_VISIT;
			end
			ST_VISIT: begin
				if (sched_end) state_d = ST_FLUSH;
				else if (visit_ok) state_d = ST_SCAN;
			end
			ST_FLUSH: begin
				if (res_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// ---- sequencer outputs ----
	always_comb begin
		req_stall = 1'b1;
		issue     = 1'b0;
		scan_done = 1'b0;
		sched_end = 1'b0;
		visit_go  = 1'b0;
		flush_go  = 1'b0;
		case (state_q)
			ST_LOAD: req_stall = 1'b0;
			ST_SCAN: begin
				issue     = rd_idx_q < count_q;
				scan_done = !issue && !vld_s1;
			end
			ST_VISIT: begin
				sched_end = !found && phase_q;
				visit_go  = !sched_end && visit_ok;
			end
			ST_FLUSH: flush_go = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- store fill and scan pointer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (load_wr) begin
				count_q <= count_q + 1'b1;
			end else if (flush_go) begin
				count_q <= '0;
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end else if (state_q != ST_SCAN) begin
				rd_idx_q <= '0;
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[AW-1:0];
	end

	// store is written only while loading and read only while scanning,
	// so the input stall is the interlock between the two ports
	sds_mem #(
		.DEPTH (MAX_REQUESTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (load_wr),
		.waddr (count_q[AW-1:0]),
		.wdata (req.request_track),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign pick_ctl.clear = sched_start || visit_go;
	assign pick_ctl.vld   = vld_s1;
	assign pick_ctl.below = below;
	assign pick_ctl.mark  = marks_q[idx_s1];

	sds_pick #(
		.AW (AW)
	) u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pick_ctl),
		.rdata       (rdata),
		.idx         (idx_s1),
		.start_head  (start_head_q),
		.track_count (track_count_q),
		.found       (found),
		.best_track  (best_track),
		.best_idx    (best_idx)
	);

	// ---- visit datapath ----
	// end track is track_count - 1, zero for an empty disk, capped at 16 bits
	always_comb begin
		tc_m1 = track_count_q - 1'b1;
		if (track_count_q == '0) begin
			end_track = '0;
		end else if (tc_m1[TCOUNT_W-1]) begin
			end_track = '1;
		end else begin
			end_track = tc_m1[TRACK_W-1:0];
		end
		// no candidate on the first sweep: visit the disk end
		if (found) begin
			target = best_track;
		end else if (sweep_right_q) begin
			target = end_track;
		end else begin
			target = '0;
		end
		seek_step = (target >= head_q) ? (target - head_q) : (head_q - target);
		seek_sum  = {1'b0, seek_q} + (SEEK_W+1)'(seek_step);
		seek_next = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 1'b0;
			marks_q      <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
			head_q       <= '0;
			seek_q       <= '0;
		end else begin
			if (sched_start) begin
				phase_q      <= 1'b0;
				pend_valid_q <= 1'b0;
				head_q       <= start_head_q;
				seek_q       <= '0;
			end else if (visit_go) begin
				if (!found) phase_q <= 1'b1;
				pend_valid_q <= 1'b1;
				head_q       <= target;
				seek_q       <= seek_next;
			end else if (flush_go) begin
				pend_valid_q <= 1'b0;
			end

			if (flush_go) begin
				marks_q <= '0;
			end else if (visit_go && found) begin
				marks_q[best_idx] <= 1'b1;
			end

			if ((visit_go && pend_valid_q) || flush_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (visit_go) begin
			pend_q.served_track <= target;
			pend_q.seek_total   <= seek_next;
			pend_q.last_visit   <= 1'b0;
		end
		if (visit_go && pend_valid_q) begin
			res_q <= pend_q;
		end else if (flush_go) begin
			res_q.served_track <= pend_q.served_track;
			res_q.seek_total   <= pend_q.seek_total;
			res_q.last_visit   <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---- checks ----
	// the disk-end visit always exists, so the flush has a held-back visit
	`SDS_ASSERT_IMP(a_flush_pending, clk, arst_n, state_q == ST_FLUSH, pend_valid_q)
	`SDS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_CNT)
	`SDS_ASSERT_NXT(a_flush_empties, clk, arst_n, flush_go, count_q == '0 && marks_q == '0)
	`SDS_ASSERT_IMP(a_marks_idle, clk, arst_n, state_q == ST_LOAD, marks_q == '0)
	`SDS_ASSERT_IMP(a_no_store_write_busy, clk, arst_n, state_q != ST_LOAD, !load_wr)
endmodule
